FILE: rtl/core/ppg_pkg.sv
// Shared constants, register codes and pipeline sideband type for the
// perspective point-to-grid block. No dependencies.
package ppg_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int GRID_SIZE_DEF   = 8;
  localparam int ROT_W           = 16;
  localparam int ROT_COL_W       = 3 * ROT_W;
  localparam int FOCAL_W         = 12;
  localparam int PROJ_W          = 18;
  localparam int CFG_DATA_W      = ROT_COL_W;
  localparam int CFG_IDX_W       = 3;
  localparam int DISPLAY_SPAN    = 1000;

  localparam logic signed [PROJ_W-1:0] PROJ_MAX = 18'sd131071;
  localparam logic signed [PROJ_W-1:0] PROJ_MIN = -18'sd131072;

  localparam int                     CAM_Z_RESET   = -512;
  localparam logic [ROT_COL_W-1:0]   ROT0_RESET    = 48'd16384;
  localparam logic [ROT_COL_W-1:0]   ROT1_RESET    = 48'd1073741824;
  localparam logic [ROT_COL_W-1:0]   ROT2_RESET    = 48'd70368744177664;
  localparam logic [FOCAL_W-1:0]     FOCAL_RESET   = 12'd289;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_X    = 3'd0,
    REG_CAM_Y    = 3'd1,
    REG_CAM_Z    = 3'd2,
    REG_ROT_COL0 = 3'd3,
    REG_ROT_COL1 = 3'd4,
    REG_ROT_COL2 = 3'd5,
    REG_FOCAL    = 3'd6
  } cfg_reg_t;

  // valid and in-front flag that ride along with each point
  typedef struct packed {
    logic valid;
    logic front;
  } side_t;

endpackage

FILE: rtl/core/ppg_view.sv
// World-to-view transform: camera offset, rotation products, dot sums and
// focal scaling, four register stages. Depends on ppg_pkg.
module ppg_view #(
  parameter int CW = ppg_pkg::COORD_WIDTH_DEF,
  localparam int VW = CW + 19,
  localparam int NW = VW + 13
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [CW-1:0]               px_in,
  input  logic signed [CW-1:0]               py_in,
  input  logic signed [CW-1:0]               pz_in,
  input  logic signed [CW-1:0]               cam_x,
  input  logic signed [CW-1:0]               cam_y,
  input  logic signed [CW-1:0]               cam_z,
  input  logic [ppg_pkg::ROT_COL_W-1:0]      rot [3],
  input  logic [ppg_pkg::FOCAL_W-1:0]        focal,
  output ppg_pkg::side_t                     side_out,
  output logic signed [NW-1:0]               nx,
  output logic signed [NW-1:0]               ny,
  output logic signed [VW-1:0]               depth
);

  localparam int PW = CW + 1 + ppg_pkg::ROT_W;

  logic                 v1, v2, v3;
  logic signed [CW:0]   dlt [3];
  logic signed [PW-1:0] prod [3][3];
  logic signed [VW-1:0] vw [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      side_out <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      side_out.valid <= v3;
      side_out.front <= vw[2] > 0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dlt[0] <= (CW+1)'(px_in) - (CW+1)'(cam_x);
      dlt[1] <= (CW+1)'(py_in) - (CW+1)'(cam_y);
      dlt[2] <= (CW+1)'(pz_in) - (CW+1)'(cam_z);
      for (int c = 0; c < 3; c++) begin
        for (int e = 0; e < 3; e++) begin
          prod[c][e] <= PW'($signed(rot[c][e*ppg_pkg::ROT_W +: ppg_pkg::ROT_W]) * dlt[e]);
        end
        vw[c] <= VW'(prod[c][0]) + VW'(prod[c][1]) + VW'(prod[c][2]);
      end
      nx    <= NW'($signed({1'b0, focal}) * vw[0]);
      ny    <= NW'($signed({1'b0, focal}) * vw[1]);
      depth <= vw[2];
    end
  end

endmodule

FILE: rtl/core/ppg_div.sv
// Pipelined floor division of focal-scaled x and y by depth, one quotient
// bit per stage, with 18-bit saturation. Depends on ppg_pkg.
module ppg_div #(
  parameter int CW = ppg_pkg::COORD_WIDTH_DEF,
  localparam int VW = CW + 19,
  localparam int NW = VW + 13
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  ppg_pkg::side_t                       side_in,
  input  logic signed [NW-1:0]                 nx,
  input  logic signed [NW-1:0]                 ny,
  input  logic signed [VW-1:0]                 depth,
  output ppg_pkg::side_t                       side_out,
  output logic signed [ppg_pkg::PROJ_W-1:0]    qx,
  output logic signed [ppg_pkg::PROJ_W-1:0]    qy
);

  localparam int QW = ppg_pkg::PROJ_W;
  localparam int MW = VW - 1;
  localparam int DW = MW + QW;

  ppg_pkg::side_t side [QW+1];
  logic [MW-1:0]  dv   [QW+1];
  logic [DW-1:0]  rem  [2][QW+1];
  logic [QW-1:0]  quo  [2][QW+1];
  logic           neg  [2][QW+1];
  logic           ovf  [2][QW+1];

  logic signed [NW-1:0] num [2];
  logic [NW:0]          mag [2];
  logic [MW-1:0]        dmag;

  always_comb begin
    num[0] = nx;
    num[1] = ny;
    dmag   = side_in.front ? depth[MW-1:0] : MW'(1);
    for (int l = 0; l < 2; l++) begin
      mag[l] = num[l][NW-1] ? (~{num[l][NW-1], num[l]} + 1'b1) : {1'b0, num[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= QW; s++) side[s] <= '0;
    end else if (en) begin
      side[0] <= side_in;
      for (int s = 1; s <= QW; s++) side[s] <= side[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dmag;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_load
    always_ff @(posedge clk) begin
      if (en) begin
        rem[l][0] <= DW'(mag[l]);
        quo[l][0] <= '0;
        neg[l][0] <= num[l][NW-1];
        ovf[l][0] <= DW'(mag[l]) >= {dmag, {QW{1'b0}}};
      end
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    localparam int K = QW - s;
    logic [DW-1:0] shd;
    assign shd = DW'(dv[s-1]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        dv[s] <= dv[s-1];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (en) begin
          neg[l][s] <= neg[l][s-1];
          ovf[l][s] <= ovf[l][s-1];
          if (rem[l][s-1] >= shd) begin
            rem[l][s] <= rem[l][s-1] - shd;
            quo[l][s] <= quo[l][s-1] | (QW'(1) << K);
          end else begin
            rem[l][s] <= rem[l][s-1];
            quo[l][s] <= quo[l][s-1];
          end
        end
      end
    end
  end

  // floor toward minus infinity: negative results round the magnitude up
  logic [QW:0]             up  [2];
  logic signed [QW-1:0]    res [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      up[l] = {1'b0, quo[l][QW]} + (QW+1)'(rem[l][QW] != '0);
      if (!neg[l][QW]) begin
        res[l] = (ovf[l][QW] || quo[l][QW][QW-1]) ? ppg_pkg::PROJ_MAX
                                                  : $signed(quo[l][QW]);
      end else if (ovf[l][QW] || up[l] > (QW+1)'(1 << (QW-1))) begin
        res[l] = ppg_pkg::PROJ_MIN;
      end else begin
        res[l] = $signed(QW'(~up[l] + 1'b1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= side[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx <= res[0];
      qy <= res[1];
    end
  end

endmodule

FILE: rtl/core/ppg_grid.sv
// Grid binning and output register. Depends on ppg_pkg.
module ppg_grid #(
  parameter int GRID_SIZE = ppg_pkg::GRID_SIZE_DEF,
  localparam int GB = $clog2(GRID_SIZE)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  ppg_pkg::side_t                    side_in,
  input  logic signed [ppg_pkg::PROJ_W-1:0] qx,
  input  logic signed [ppg_pkg::PROJ_W-1:0] qy,
  output logic                              out_valid,
  output logic                              in_front,
  output logic signed [ppg_pkg::PROJ_W-1:0] proj_x,
  output logic signed [ppg_pkg::PROJ_W-1:0] proj_y,
  output logic                              lit,
  output logic [GB-1:0]                     grid_col,
  output logic [GB-1:0]                     grid_row
);

  localparam int QW    = ppg_pkg::PROJ_W;
  localparam int HALF  = ppg_pkg::DISPLAY_SPAN / 2;
  localparam int CELL  = ppg_pkg::DISPLAY_SPAN / GRID_SIZE;
  localparam int SPAN  = CELL * GRID_SIZE;

  logic signed [QW:0] t [2];
  logic               on [2];
  logic [GB-1:0]      bin [2];
  logic               hit;

  always_comb begin
    t[0] = (QW+1)'(qx) + (QW+1)'(HALF);
    t[1] = (QW+1)'(qy) + (QW+1)'(HALF);
    for (int a = 0; a < 2; a++) begin
      on[a]  = (t[a] >= 0) && (t[a] < (QW+1)'(SPAN));
      bin[a] = '0;
      for (int j = 1; j < GRID_SIZE; j++) begin
        if (t[a] >= (QW+1)'(j * CELL)) bin[a] = GB'(j);
      end
    end
    hit = side_in.front && on[0] && on[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= side_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_front <= side_in.front;
      proj_x   <= side_in.front ? qx : '0;
      proj_y   <= side_in.front ? qy : '0;
      lit      <= hit;
      grid_col <= hit ? bin[0] : '0;
      grid_row <= hit ? bin[1] : '0;
    end
  end

endmodule

FILE: rtl/core/perspective_point_to_grid.sv
// Top level of the perspective point-to-grid pipeline: config registers,
// stream ports and the view, divider and grid stages. Depends on ppg_pkg,
// ppg_view, ppg_div and ppg_grid.
//
// Usage:
//   s_* carries world points (x, y, z, Q8.8) in; m_* carries one result per
//   point out, in order. cfg_* writes camera position, rotation columns and
//   focal length. cfg_ready is always high and writes are registered. The
//   user makes writes only while no point is in flight; it is not enforced.
//   Pipeline: 4 transform stages, 20 divider stages and 1 output register
//   lie between an input transaction and m_tvalid.
//   Throughput: one point per cycle unless stalled. The divider retires one
//   quotient bit per stage, which sets the depth of the pipeline.
//   Stall: the pipeline advances only when the output register is empty or
//   taken; s_tready drops with it, so nothing is lost or repeated.
//   Reset: rst (synchronous) empties the pipeline and loads the camera at
//   z = -2.0 looking down +z, identity rotation, focal length 289.
module perspective_point_to_grid #(
  parameter int COORD_WIDTH = ppg_pkg::COORD_WIDTH_DEF,
  parameter int GRID_SIZE   = ppg_pkg::GRID_SIZE_DEF,
  localparam int GB    = $clog2(GRID_SIZE),
  localparam int IN_W  = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((2 + 2 * ppg_pkg::PROJ_W + 2 * GB + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // point_x, point_y, point_z, zero pad
  input  logic [IN_W-1:0]                     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // in_front, proj_x, proj_y, lit, grid_col, grid_row, zero pad
  output logic [OUT_W-1:0]                    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int VW = CW + 19;
  localparam int NW = VW + 13;
  localparam int QW = ppg_pkg::PROJ_W;

  // configuration registers
  logic signed [CW-1:0]               cam_x, cam_y, cam_z;
  logic [ppg_pkg::ROT_COL_W-1:0]      rot [3];
  logic [ppg_pkg::FOCAL_W-1:0]        focal;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x  <= '0;
      cam_y  <= '0;
      cam_z  <= CW'(ppg_pkg::CAM_Z_RESET);
      rot[0] <= ppg_pkg::ROT0_RESET;
      rot[1] <= ppg_pkg::ROT1_RESET;
      rot[2] <= ppg_pkg::ROT2_RESET;
      focal  <= ppg_pkg::FOCAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppg_pkg::REG_CAM_X:    cam_x  <= cfg_data[CW-1:0];
        ppg_pkg::REG_CAM_Y:    cam_y  <= cfg_data[CW-1:0];
        ppg_pkg::REG_CAM_Z:    cam_z  <= cfg_data[CW-1:0];
        ppg_pkg::REG_ROT_COL0: rot[0] <= cfg_data;
        ppg_pkg::REG_ROT_COL1: rot[1] <= cfg_data;
        ppg_pkg::REG_ROT_COL2: rot[2] <= cfg_data;
        ppg_pkg::REG_FOCAL:    focal  <= cfg_data[ppg_pkg::FOCAL_W-1:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // whole pipeline moves together; output register empty or being taken
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  ppg_pkg::side_t        view_side, div_side;
  logic signed [NW-1:0]  nx, ny;
  logic signed [VW-1:0]  depth;
  logic signed [QW-1:0]  qx, qy;

  ppg_view #(.CW(CW)) u_view (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid && s_tready),
    .px_in    (s_tdata[0 +: CW]),
    .py_in    (s_tdata[CW +: CW]),
    .pz_in    (s_tdata[2*CW +: CW]),
    .cam_x    (cam_x),
    .cam_y    (cam_y),
    .cam_z    (cam_z),
    .rot      (rot),
    .focal    (focal),
    .side_out (view_side),
    .nx       (nx),
    .ny       (ny),
    .depth    (depth)
  );

  ppg_div #(.CW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (view_side),
    .nx       (nx),
    .ny       (ny),
    .depth    (depth),
    .side_out (div_side),
    .qx       (qx),
    .qy       (qy)
  );

  logic                 in_front, lit;
  logic signed [QW-1:0] proj_x, proj_y;
  logic [GB-1:0]        grid_col, grid_row;

  ppg_grid #(.GRID_SIZE(GRID_SIZE)) u_grid (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .side_in   (div_side),
    .qx        (qx),
    .qy        (qy),
    .out_valid (m_tvalid),
    .in_front  (in_front),
    .proj_x    (proj_x),
    .proj_y    (proj_y),
    .lit       (lit),
    .grid_col  (grid_col),
    .grid_row  (grid_row)
  );

  assign m_tdata = OUT_W'({grid_row, grid_col, lit, proj_y, proj_x, in_front});

endmodule

FILE: rtl/core/ppg_checker.sv
// Port-level checks for perspective_point_to_grid and the bind that
// attaches them. Depends on ppg_pkg and the top level.
module ppg_checker #(
  parameter int GRID_SIZE = ppg_pkg::GRID_SIZE_DEF,
  parameter int OUT_W     = 48
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  localparam int QW  = ppg_pkg::PROJ_W;
  localparam int GB  = $clog2(GRID_SIZE);
  localparam int LIT = 1 + 2 * QW;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_lit_front: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[LIT] |-> m_tdata[0])
    else $error("lit point behind camera");

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[2*QW:1] == '0)
    else $error("behind-camera point has nonzero projection");

  a_unlit_cell: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[LIT] |-> m_tdata[LIT+2*GB:LIT+1] == '0)
    else $error("unlit point has nonzero cell");

endmodule

bind perspective_point_to_grid ppg_checker #(
  .GRID_SIZE (GRID_SIZE),
  .OUT_W     (OUT_W)
) u_ppg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
